@@ src/wmfb_pkg.sv @@
// Shared package for the 802.11 management frame builder.
// Holds the request and status codes, the register map, the frame constants and
// the controller-to-datapath command and status structs. No dependencies.
`default_nettype none

package wmfb_pkg;

    // Sizing of the frame and of the SSID store.
    localparam int MAX_FRAME_LEN = 128;
    localparam int SSID_CAPACITY = 32;
    localparam int SSID_ROWS     = SSID_CAPACITY / 4;
    localparam int ROW_W         = $clog2(SSID_ROWS);
    localparam int HDR_LEN       = 24;
    localparam int FIXED_LEN     = 12;
    localparam int WORD_IDX_W    = 5;

    // Request modes.
    typedef enum logic [2:0] {
        MODE_SSID_WR    = 3'd0,
        MODE_BEACON     = 3'd1,
        MODE_PROBE_REQ  = 3'd2,
        MODE_PROBE_RESP = 3'd3,
        MODE_DEAUTH     = 3'd4
    } t_mode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAN = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SENDER   = 3'd0,
        CFG_DEST     = 3'd1,
        CFG_BSSID    = 3'd2,
        CFG_INTERVAL = 3'd3,
        CFG_CAP      = 3'd4,
        CFG_COUNTRY  = 3'd5,
        CFG_REASON   = 3'd6
    } t_cfg_idx;

    // Frame control values per frame subtype.
    localparam logic [15:0] FC_BEACON     = 16'h0080;
    localparam logic [15:0] FC_PROBE_REQ  = 16'h0040;
    localparam logic [15:0] FC_PROBE_RESP = 16'h0050;
    localparam logic [15:0] FC_DEAUTH     = 16'h00c0;

    // Register reset values and defaults used when a register holds zero.
    localparam logic [47:0] MAC_BCAST      = 48'hffff_ffff_ffff;
    localparam logic [15:0] DEF_INTERVAL   = 16'd100;
    localparam logic [15:0] DEF_CAP        = 16'h0001;
    localparam logic [15:0] DEF_REASON     = 16'h0001;
    localparam logic [23:0] DEF_COUNTRY    = 24'h205345;
    localparam logic [7:0]  ASCII_SPACE    = 8'h20;

    // Supported rates, first transmitted byte in the low bits.
    localparam logic [63:0] RATES = 64'h2418_120c_968b_8482;

    // Channel range.
    localparam logic [7:0] CHAN_MIN = 8'd1;
    localparam logic [7:0] CHAN_MAX = 8'd13;

    // Element ids.
    localparam logic [7:0] EID_SSID    = 8'd0;
    localparam logic [7:0] EID_RATES   = 8'd1;
    localparam logic [7:0] EID_DS      = 8'd3;
    localparam logic [7:0] EID_COUNTRY = 8'd7;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;     // capture a frame request
        logic ssid_wr;  // write one SSID byte
        logic adv;      // load the next word into the output register
    } t_dp_cmd;

    // Datapath status back to the controller.
    typedef struct packed {
        logic out_free;   // output register can take a word this cycle
        logic last_word;  // the word being built is the final one
    } t_dp_sts;

endpackage

`default_nettype wire

@@ src/wmfb_ctrl.sv @@
// Controller state machine of the management frame builder.
// Depends on wmfb_pkg for the mode codes and the command and status structs.
`default_nettype none

module wmfb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [2:0]        i_mode,
    input  wire wmfb_pkg::t_dp_sts i_sts,
    output logic                   o_in_ready,
    output wmfb_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   accept;
    logic   is_frame;

    assign accept   = i_in_valid && r_in_ready;
    assign is_frame = (i_mode == wmfb_pkg::MODE_BEACON)
                   || (i_mode == wmfb_pkg::MODE_PROBE_REQ)
                   || (i_mode == wmfb_pkg::MODE_PROBE_RESP)
                   || (i_mode == wmfb_pkg::MODE_DEAUTH);

    always_comb begin
        o_cmd.load    = accept && is_frame;
        o_cmd.ssid_wr = accept && (i_mode == wmfb_pkg::MODE_SSID_WR);
        o_cmd.adv     = (r_state == S_EMIT) && i_sts.out_free;
    end

    assign o_in_ready = r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state    <= S_EMIT;
                        r_in_ready <= 1'b0;
                    end
                end
                S_EMIT: begin
                    if (o_cmd.adv && i_sts.last_word) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    a_no_ready_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !r_in_ready)
        else $error("request ready while a frame is being emitted");

    a_load_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EMIT))
        else $error("frame request did not start emission");

    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.adv && i_sts.last_word) |=> r_in_ready)
        else $error("input not ready after final word");

    a_ssid_wr_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ssid_wr |=> (r_state == S_IDLE))
        else $error("SSID write left the idle state");

endmodule

`default_nettype wire

@@ src/wmfb_datapath.sv @@
// Datapath of the management frame builder: registers, SSID store, byte selection
// and the output word register. Depends on wmfb_pkg.
`default_nettype none

module wmfb_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wmfb_pkg::t_dp_cmd i_cmd,
    output wmfb_pkg::t_dp_sts      o_sts,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [47:0]       i_cfg_data,
    input  wire logic [2:0]        i_mode,
    input  wire logic [11:0]       i_sequence_req,
    input  wire logic [7:0]        i_channel,
    input  wire logic [5:0]        i_ssid_length,
    input  wire logic [4:0]        i_ssid_index,
    input  wire logic [7:0]        i_ssid_byte,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [31:0]            o_data_word,
    output logic [2:0]             o_byte_count,
    output logic                   o_last,
    output logic [1:0]             o_status
);

    localparam int WW = wmfb_pkg::WORD_IDX_W;

    // Configuration registers.
    logic [47:0] r_sender, r_dest, r_bssid;
    logic [15:0] r_interval, r_cap, r_reason;
    logic [23:0] r_country;

    // SSID store, four bytes to a row.
    logic [31:0] r_ssid_rows [wmfb_pkg::SSID_ROWS];

    // Captured request.
    logic [2:0]    r_mode;
    logic [11:0]   r_seq;
    logic [7:0]    r_chan;
    logic [5:0]    r_slen;
    logic [6:0]    r_fbase, r_ebase, r_flen;
    logic [WW-1:0] r_nwords, r_word;
    logic [1:0]    r_status;
    logic [15:0]   r_prev_hi;

    // Output register.
    logic        r_out_valid;
    logic [31:0] r_data;
    logic [2:0]  r_cnt;
    logic        r_last;
    logic [1:0]  r_ostat;

    // Request decode.
    logic [5:0]    slen_sat;
    logic [6:0]    n_fbase, n_ebase, n_flen;
    logic [WW-1:0] n_nwords;
    logic [1:0]    n_status;
    logic          chan_bad, too_long;

    assign slen_sat = (i_ssid_length > 6'(wmfb_pkg::SSID_CAPACITY))
                    ? 6'(wmfb_pkg::SSID_CAPACITY) : i_ssid_length;
    assign n_fbase  = (i_mode == wmfb_pkg::MODE_PROBE_REQ)
                    ? 7'(wmfb_pkg::HDR_LEN)
                    : 7'(wmfb_pkg::HDR_LEN + wmfb_pkg::FIXED_LEN);
    assign n_ebase  = n_fbase + 7'd2 + 7'(slen_sat);

    always_comb begin
        if (i_mode == wmfb_pkg::MODE_DEAUTH) begin
            n_flen = 7'(wmfb_pkg::HDR_LEN + 2);
        end else if (i_mode == wmfb_pkg::MODE_BEACON) begin
            n_flen = n_ebase + 7'd21;
        end else begin
            n_flen = n_ebase + 7'd13;
        end
    end

    assign chan_bad = (i_channel < wmfb_pkg::CHAN_MIN) || (i_channel > wmfb_pkg::CHAN_MAX);
    assign too_long = int'(n_flen) > wmfb_pkg::MAX_FRAME_LEN;

    always_comb begin
        priority if (chan_bad) begin
            n_status = wmfb_pkg::ST_BAD_CHAN;
        end else if (too_long) begin
            n_status = wmfb_pkg::ST_TOO_LONG;
        end else begin
            n_status = wmfb_pkg::ST_OK;
        end
    end

    assign n_nwords = (n_status != wmfb_pkg::ST_OK) ? WW'(1)
                    : WW'((8'(n_flen) + 8'd3) >> 2);

    // Effective field values.
    logic [15:0] fc, intv, cap, reason;
    logic [47:0] bss;
    logic [7:0]  c0, c1, c2;

    always_comb begin
        unique case (r_mode)
            wmfb_pkg::MODE_BEACON:     fc = wmfb_pkg::FC_BEACON;
            wmfb_pkg::MODE_PROBE_REQ:  fc = wmfb_pkg::FC_PROBE_REQ;
            wmfb_pkg::MODE_PROBE_RESP: fc = wmfb_pkg::FC_PROBE_RESP;
            default:                   fc = wmfb_pkg::FC_DEAUTH;
        endcase
    end

    always_comb begin
        priority if (r_bssid != '0) begin
            bss = r_bssid;
        end else if (r_mode == wmfb_pkg::MODE_PROBE_REQ) begin
            bss = wmfb_pkg::MAC_BCAST;
        end else begin
            bss = r_sender;
        end
    end

    assign intv   = (r_interval != '0) ? r_interval : wmfb_pkg::DEF_INTERVAL;
    assign cap    = (r_cap != '0) ? r_cap : wmfb_pkg::DEF_CAP;
    assign reason = (r_reason != '0) ? r_reason : wmfb_pkg::DEF_REASON;

    always_comb begin
        c0 = r_country[7:0];
        c1 = r_country[15:8];
        c2 = r_country[23:16];
        priority if (c0 == '0 || c1 == '0) begin
            c0 = wmfb_pkg::DEF_COUNTRY[7:0];
            c1 = wmfb_pkg::DEF_COUNTRY[15:8];
            c2 = wmfb_pkg::DEF_COUNTRY[23:16];
        end else if (c2 == '0) begin
            c2 = wmfb_pkg::ASCII_SPACE;
        end else begin
            c2 = r_country[23:16];
        end
    end

    // Byte images of the frame sections, first byte lowest.
    logic [191:0] hdr;
    logic [95:0]  fixv;
    logic [167:0] tail;

    assign hdr  = {r_seq, 4'h0, bss, r_sender, r_dest, 16'h0000, fc};
    assign fixv = {cap, intv, 64'h0};
    assign tail = {8'd20, 8'd13, 8'd1, c2, c1, c0, 8'd6, wmfb_pkg::EID_COUNTRY,
                   r_chan, 8'd1, wmfb_pkg::EID_DS, wmfb_pkg::RATES, 8'd8,
                   wmfb_pkg::EID_RATES};

    // SSID bytes of one word come from the high half of one row and the low
    // half of the next, since the SSID always starts two bytes into a word.
    logic [4:0]                  rowoff;
    logic [wmfb_pkg::ROW_W-1:0]  row_idx;
    logic [31:0]                 row_cur;

    assign rowoff  = 5'((r_fbase + 7'd2) >> 2);
    assign row_idx = wmfb_pkg::ROW_W'(r_word - rowoff);
    assign row_cur = r_ssid_rows[row_idx];

    logic [31:0] word;

    for (genvar gb = 0; gb < 4; gb++) begin : g_lane
        logic [6:0] pos, doff, foff;
        logic [7:0] sb, lane_byte;

        assign pos  = {r_word, 2'(gb)};
        assign doff = pos - r_ebase;
        assign foff = pos - 7'(wmfb_pkg::HDR_LEN);

        if (gb < 2) begin : g_prev
            assign sb = r_prev_hi[gb*8 +: 8];
        end else begin : g_cur
            assign sb = row_cur[(gb-2)*8 +: 8];
        end

        always_comb begin
            priority if (pos >= r_flen) begin
                lane_byte = '0;
            end else if (pos < 7'(wmfb_pkg::HDR_LEN)) begin
                lane_byte = hdr[{pos[4:0], 3'b000} +: 8];
            end else if (r_mode == wmfb_pkg::MODE_DEAUTH) begin
                lane_byte = foff[0] ? reason[15:8] : reason[7:0];
            end else if (pos < r_fbase) begin
                lane_byte = fixv[{foff[3:0], 3'b000} +: 8];
            end else if (pos == r_fbase) begin
                lane_byte = wmfb_pkg::EID_SSID;
            end else if (pos == r_fbase + 7'd1) begin
                lane_byte = {2'b00, r_slen};
            end else if (pos < r_ebase) begin
                lane_byte = sb;
            end else begin
                lane_byte = tail[{doff[4:0], 3'b000} +: 8];
            end
        end

        assign word[gb*8 +: 8] = lane_byte;
    end

    logic       cur_last, err;
    logic [2:0] cur_cnt;

    assign err      = (r_status != wmfb_pkg::ST_OK);
    assign cur_last = (r_word == r_nwords - WW'(1));
    assign cur_cnt  = err ? 3'd0
                    : cur_last ? 3'(r_flen - {r_word, 2'b00}) : 3'd4;

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.last_word = cur_last;

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_word      <= '0;
            r_sender    <= '0;
            r_dest      <= wmfb_pkg::MAC_BCAST;
            r_bssid     <= '0;
            r_interval  <= wmfb_pkg::DEF_INTERVAL;
            r_cap       <= wmfb_pkg::DEF_CAP;
            r_country   <= wmfb_pkg::DEF_COUNTRY;
            r_reason    <= wmfb_pkg::DEF_REASON;
        end else begin
            if (i_cmd.adv) begin
                r_out_valid <= 1'b1;
                r_word      <= r_word + WW'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_word <= '0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    wmfb_pkg::CFG_SENDER:   r_sender   <= i_cfg_data;
                    wmfb_pkg::CFG_DEST:     r_dest     <= i_cfg_data;
                    wmfb_pkg::CFG_BSSID:    r_bssid    <= i_cfg_data;
                    wmfb_pkg::CFG_INTERVAL: r_interval <= i_cfg_data[15:0];
                    wmfb_pkg::CFG_CAP:      r_cap      <= i_cfg_data[15:0];
                    wmfb_pkg::CFG_COUNTRY:  r_country  <= i_cfg_data[23:0];
                    wmfb_pkg::CFG_REASON:   r_reason   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_seq    <= i_sequence_req;
            r_chan   <= i_channel;
            r_slen   <= slen_sat;
            r_fbase  <= n_fbase;
            r_ebase  <= n_ebase;
            r_flen   <= n_flen;
            r_nwords <= n_nwords;
            r_status <= n_status;
        end
        if (i_cmd.ssid_wr && ({1'b0, i_ssid_index} < 6'(wmfb_pkg::SSID_CAPACITY))) begin
            r_ssid_rows[i_ssid_index[4:2]][{i_ssid_index[1:0], 3'b000} +: 8] <= i_ssid_byte;
        end
        if (i_cmd.adv) begin
            r_data    <= err ? 32'h0 : word;
            r_cnt     <= cur_cnt;
            r_last    <= cur_last;
            r_ostat   <= r_status;
            r_prev_hi <= row_cur[31:16];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_word  = r_data;
    assign o_byte_count = r_cnt;
    assign o_last       = r_last;
    assign o_status     = r_ostat;

endmodule

`default_nettype wire

@@ src/wifi_mgmt_frame_builder_unit.sv @@
// 802.11 management frame builder, top level. Depends on wmfb_pkg, wmfb_ctrl, wmfb_datapath.
// A request is captured on acceptance and the controller enters its emit state; from there
// the first word is loaded into the output register. A frame of N words (7 to 23, or one
// error word) moves one word a cycle through the byte selection into the single output
// register while the consumer keeps up, and a write of an SSID byte gives no result.
// Reset (synchronous, active low) idles the block and loads the register defaults.
`default_nettype none

module wifi_mgmt_frame_builder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    // Request channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_mode,
    input  wire logic [11:0] i_sequence_req,
    input  wire logic [7:0]  i_channel,
    input  wire logic [5:0]  i_ssid_length,
    input  wire logic [4:0]  i_ssid_index,
    input  wire logic [7:0]  i_ssid_byte,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_data_word,
    output logic [2:0]       o_byte_count,
    output logic             o_last,
    output logic [1:0]       o_status
);

    // The controller decides when a request is taken and when the next word of
    // a frame moves into the output register. The datapath captures the
    // request, works out the frame layout (SSID and element offsets, total
    // length, word count and error status) and builds each word from four
    // byte selectors that each pick from the header, the fixed fields, the
    // SSID store or the trailing elements.
    wmfb_pkg::t_dp_cmd dp_cmd;
    wmfb_pkg::t_dp_sts dp_sts;

    wmfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (dp_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    // The output register sits in the datapath, so a finished word can wait
    // for the consumer while the controller already holds the next request
    // slot open once the final word has been loaded.
    wmfb_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_sequence_req (i_sequence_req),
        .i_channel      (i_channel),
        .i_ssid_length  (i_ssid_length),
        .i_ssid_index   (i_ssid_index),
        .i_ssid_byte    (i_ssid_byte),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_data_word    (o_data_word),
        .o_byte_count   (o_byte_count),
        .o_last         (o_last),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire
